>>> hw/rtl/smpq_pkg.sv
// Package for the stable max-priority queue: codes, microcode format and microcode store.
`default_nettype none

package smpq_pkg;

	// Default number of entries the queue can hold.
	localparam int DEFAULT_CAPACITY = 64;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SERVE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Microprogram counter width and step addresses.
	localparam int UPC_W = 4;

	localparam logic [UPC_W-1:0] STEP_IDLE      = 4'd0;
	localparam logic [UPC_W-1:0] STEP_DISP_INS  = 4'd1;
	localparam logic [UPC_W-1:0] STEP_DISP_SRV  = 4'd2;
	localparam logic [UPC_W-1:0] STEP_DISP_CLR  = 4'd3;
	localparam logic [UPC_W-1:0] STEP_CLEAR     = 4'd4;
	localparam logic [UPC_W-1:0] STEP_INS       = 4'd5;
	localparam logic [UPC_W-1:0] STEP_PUSH      = 4'd6;
	localparam logic [UPC_W-1:0] STEP_SRV       = 4'd7;
	localparam logic [UPC_W-1:0] STEP_RD_FIRST  = 4'd8;
	localparam logic [UPC_W-1:0] STEP_LOAD_BEST = 4'd9;
	localparam logic [UPC_W-1:0] STEP_COMPARE   = 4'd10;
	localparam logic [UPC_W-1:0] STEP_RD_LAST   = 4'd11;
	localparam logic [UPC_W-1:0] STEP_MOVE_LAST = 4'd12;
	localparam logic [UPC_W-1:0] STEP_DONE_FULL = 4'd13;
	localparam logic [UPC_W-1:0] STEP_DONE_OK   = 4'd14;
	localparam logic [UPC_W-1:0] STEP_DONE_EMPT = 4'd15;

	// Datapath operations selected by one control word.
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_LATCH,
		UOP_CLEAR,
		UOP_PUSH,
		UOP_RD_FIRST,
		UOP_LOAD_BEST,
		UOP_COMPARE,
		UOP_RD_LAST,
		UOP_MOVE_LAST
	} uop_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NSTART,
		COND_IS_INS,
		COND_IS_SRV,
		COND_NOT_CLR,
		COND_FULL,
		COND_EMPTY,
		COND_MORE
	} ucond_t;

	typedef struct packed {
		uop_t             op;
		ucond_t           cond;
		logic [UPC_W-1:0] target;
		logic             emit;
		logic [1:0]       status;
		logic             tag_best;
	} ucode_t;

	// Microcode store: one control word per step.
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
		ucode_t w;
		w = '{op: UOP_NOP, cond: COND_NEVER, target: STEP_IDLE,
			emit: 1'b0, status: ST_OK, tag_best: 1'b0};
		case (step)
			STEP_IDLE: begin
				w.op = UOP_LATCH; w.cond = COND_NSTART; w.target = STEP_IDLE;
			end
			STEP_DISP_INS: begin
				w.cond = COND_IS_INS; w.target = STEP_INS;
			end
			STEP_DISP_SRV: begin
				w.cond = COND_IS_SRV; w.target = STEP_SRV;
			end
			STEP_DISP_CLR: begin
				w.cond = COND_NOT_CLR; w.target = STEP_DONE_OK;
			end
			STEP_CLEAR: begin
				w.op = UOP_CLEAR; w.cond = COND_ALWAYS; w.target = STEP_IDLE;
				w.emit = 1'b1; w.status = ST_OK;
			end
			STEP_INS: begin
				w.cond = COND_FULL; w.target = STEP_DONE_FULL;
			end
			STEP_PUSH: begin
				w.op = UOP_PUSH; w.cond = COND_ALWAYS; w.target = STEP_IDLE;
				w.emit = 1'b1; w.status = ST_OK;
			end
			STEP_SRV: begin
				w.cond = COND_EMPTY; w.target = STEP_DONE_EMPT;
			end
			STEP_RD_FIRST: begin
				w.op = UOP_RD_FIRST;
			end
			STEP_LOAD_BEST: begin
				w.op = UOP_LOAD_BEST;
			end
			STEP_COMPARE: begin
				w.op = UOP_COMPARE; w.cond = COND_MORE; w.target = STEP_COMPARE;
			end
			STEP_RD_LAST: begin
				w.op = UOP_RD_LAST;
			end
			STEP_MOVE_LAST: begin
				w.op = UOP_MOVE_LAST; w.cond = COND_ALWAYS; w.target = STEP_IDLE;
				w.emit = 1'b1; w.status = ST_OK; w.tag_best = 1'b1;
			end
			STEP_DONE_FULL: begin
				w.cond = COND_ALWAYS; w.target = STEP_IDLE;
				w.emit = 1'b1; w.status = ST_FULL;
			end
			STEP_DONE_OK: begin
				w.cond = COND_ALWAYS; w.target = STEP_IDLE;
				w.emit = 1'b1; w.status = ST_OK;
			end
			STEP_DONE_EMPT: begin
				w.cond = COND_ALWAYS; w.target = STEP_IDLE;
				w.emit = 1'b1; w.status = ST_EMPTY;
			end
			default: begin
				w.cond = COND_ALWAYS; w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stable_max_priority_queue_core.sv
// Top level of the stable max-priority queue: microcoded sequencer, entry memory and scan datapath.
`default_nettype none

// The done strobe follows the accepting edge once the steps for the request's kind have run;
// a serve over stored entries takes longer as the queue grows, since its scan reads one memory
// entry per cycle. Throughput: one request at a time; busy drops in the cycle that shows the
// result, so the next request can be accepted there. Reset clears the step counter, count,
// arrival counter and done.
module stable_max_priority_queue_core
	import smpq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] priority_req,
	input  wire logic [15:0] tag,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      served_tag
);

	// Address width of the entry memory, width of the entry count, and width of the scan
	// indices, which run one past the count.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY + 2);

	typedef struct packed {
		logic [31:0] prio;
		logic [31:0] arrival;
		logic [15:0] tag;
	} entry_t;

	// Sequencer state.
	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_d;
	ucode_t           uc;
	logic             jump;

	// Latched request.
	logic [1:0]  kind_q;
	logic [31:0] prio_q;
	logic [15:0] tag_q;

	// Queue bookkeeping.
	logic [CW-1:0] count_q;
	logic [CW-1:0] last_idx;
	logic [31:0]   arrival_q;

	// Scan registers: idx_q is the next address to read, cmp_idx_q the entry whose data
	// arrives this cycle, best_* the winner so far.
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cmp_idx_q;
	logic [AW-1:0] best_idx_q;
	entry_t        best_q;
	logic          cand_wins;
	logic          cand_valid;

	// Entry memory, one write port and one registered read port.
	entry_t        mem [CAPACITY];
	entry_t        mem_rdata_q;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_we;

	// Result register.
	logic        done_q;
	logic [1:0]  status_q;
	logic [15:0] served_tag_q;

	// ------------------------------------------------------------------
	// Sequencer: the control word comes from the microcode store; the next step is either
	// the word's jump target or the following step.
	// ------------------------------------------------------------------
	assign uc       = ucode_rom(upc_q);
	assign last_idx = count_q - CW'(1);

	always_comb begin
		case (uc.cond)
			COND_NEVER:   jump = 1'b0;
			COND_ALWAYS:  jump = 1'b1;
			COND_NSTART:  jump = !start;
			COND_IS_INS:  jump = (kind_q == KIND_INSERT);
			COND_IS_SRV:  jump = (kind_q == KIND_SERVE);
			COND_NOT_CLR: jump = (kind_q != KIND_CLEAR);
			COND_FULL:    jump = (count_q == CW'(CAPACITY));
			COND_EMPTY:   jump = (count_q == '0);
			COND_MORE:    jump = ((cmp_idx_q + IW'(1)) < IW'(count_q));
			default:      jump = 1'b0;
		endcase
	end

	assign upc_d = jump ? uc.target : upc_q + UPC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	assign busy = (upc_q != STEP_IDLE);

	// ------------------------------------------------------------------
	// Memory port selection.
	// ------------------------------------------------------------------
	always_comb begin
		mem_raddr = idx_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = '{prio: prio_q, arrival: arrival_q, tag: tag_q};
		case (uc.op)
			UOP_RD_FIRST: begin
				mem_raddr = '0;
			end
			UOP_RD_LAST: begin
				mem_raddr = last_idx[AW-1:0];
			end
			UOP_PUSH: begin
				mem_we = 1'b1;
			end
			UOP_MOVE_LAST: begin
				// The last entry fills the hole left by the served one.
				mem_we    = 1'b1;
				mem_waddr = best_idx_q;
				mem_wdata = mem_rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	// ------------------------------------------------------------------
	// Ranking: higher priority wins; on equal priority the smaller arrival stamp wins. A tie
	// on both keeps the earlier (lower) slot, so the compare is strict.
	// ------------------------------------------------------------------
	assign cand_valid = (cmp_idx_q < IW'(count_q));
	assign cand_wins  = (mem_rdata_q.prio > best_q.prio) ||
		((mem_rdata_q.prio == best_q.prio) && (mem_rdata_q.arrival < best_q.arrival));

	// Bookkeeping registers that must come out of reset cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			arrival_q <= '0;
		end else begin
			case (uc.op)
				UOP_CLEAR: begin
					count_q   <= '0;
					arrival_q <= '0;
				end
				UOP_PUSH: begin
					count_q   <= count_q + CW'(1);
					arrival_q <= arrival_q + 32'd1;
				end
				UOP_RD_LAST: begin
					count_q <= last_idx;
				end
				default: begin
				end
			endcase
		end
	end

	// Request and scan registers; their contents only matter once a step has loaded them.
	always_ff @(posedge clk) begin
		case (uc.op)
			UOP_LATCH: begin
				kind_q <= kind;
				prio_q <= priority_req;
				tag_q  <= tag;
			end
			UOP_RD_FIRST: begin
				idx_q <= IW'(1);
			end
			UOP_LOAD_BEST: begin
				best_q     <= mem_rdata_q;
				best_idx_q <= '0;
				cmp_idx_q  <= idx_q;
				idx_q      <= idx_q + IW'(1);
			end
			UOP_COMPARE: begin
				if (cand_valid && cand_wins) begin
					best_q     <= mem_rdata_q;
					best_idx_q <= cmp_idx_q[AW-1:0];
				end
				cmp_idx_q <= idx_q;
				idx_q     <= idx_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result register: a control word with its emit bit set produces one result, shown for
	// exactly one cycle after the step that emits it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= uc.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.emit) begin
			status_q     <= uc.status;
			served_tag_q <= uc.tag_best ? best_q.tag : 16'd0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign served_tag = served_tag_q;

`ifndef SYNTHESIS
	// The sequencer only returns to idle through a step that emits a result.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sequencer went idle without a result");

	// An accepted request always occupies the sequencer in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start the sequencer");

	// The entry count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// A serve reported on an empty queue leaves the queue empty.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> (count_q == '0))
		else $error("empty status with entries present");

	// During the scan the current winner is always a stored entry.
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == STEP_COMPARE) |-> (CW'(best_idx_q) < count_q))
		else $error("scan winner outside stored entries");
`endif

endmodule

`default_nettype wire
